[hdl/pressure_banded_pulse_driver_macros.svh]
// ----------------------------------------------------------------------------
// Pressure banded pulse driver: assertion macros
// Clocked implication checks used by the driver's assertions.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_BANDED_PULSE_DRIVER_MACROS_SVH
`define PRESSURE_BANDED_PULSE_DRIVER_MACROS_SVH

// same-cycle implication
`define PBPD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pbpd same-cycle check failed");

// next-cycle implication
`define PBPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pbpd next-cycle check failed");

`endif

[hdl/pbpd_pkg.sv]
// ----------------------------------------------------------------------------
// pbpd_pkg
// Types, register indexes and constants of the pressure banded pulse driver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbpd_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int TIME_BITS   = 16;
  localparam int BANDS       = 4;
  localparam int BAND_BITS   = 2;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 2 * TIME_BITS;

  // phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ON   = 2'd1;
  localparam logic [1:0] PH_OFF  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD0 = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD1 = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD2 = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD3 = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TIMES0     = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TIMES1     = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TIMES2     = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TIMES3     = 4'd7;

  // reset values: thresholds in ADC codes, times as on/off = 25 ms / 25 ms
  localparam logic [SAMPLE_BITS-1:0] THRESHOLD0_RST = 12'd586;
  localparam logic [SAMPLE_BITS-1:0] THRESHOLD1_RST = 12'd652;
  localparam logic [SAMPLE_BITS-1:0] THRESHOLD2_RST = 12'd725;
  localparam logic [SAMPLE_BITS-1:0] THRESHOLD3_RST = 12'd798;
  localparam logic [CFG_DATA_BITS-1:0] TIMES_RST    = 32'd1638425;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   clear_peak;
  } item_t;

  typedef struct packed {
    logic                   relay_on;
    logic [1:0]             phase;
    logic [BAND_BITS-1:0]   band;
    logic [SAMPLE_BITS-1:0] peak_sample;
  } result_t;

endpackage

[hdl/pressure_banded_pulse_driver.sv]
// ----------------------------------------------------------------------------
// pressure_banded_pulse_driver
// Banded on/off injector relay sequencer driven by 1 ms pressure samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Each transfer on the item channel is one millisecond tick with a 12-bit
// pressure ADC code; each tick produces exactly one result transfer carrying
// the relay drive, the phase (idle / on / off), the selected band and the
// running peak sample. The block takes one item per clock cycle, back to back,
// while the result channel does not stall. An item transfer loads the input
// register; once the result register is free, a single pass of comparators and
// the 16-bit elapsed counter loads the result register and result valid rises.
// The result register and the input register let a new item be taken while
// the previous result waits on result_stall. Thresholds and per-band on/off
// times are written through the cfg port (always ready); write them only while
// no tick is in flight.

`include "pressure_banded_pulse_driver_macros.svh"

module pressure_banded_pulse_driver (
  input  logic                                 clk,
  input  logic                                 rst,
  // tick channel
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  pbpd_pkg::item_t                      item,
  // result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output pbpd_pkg::result_t                    result,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pbpd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [pbpd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  import pbpd_pkg::*;

  // configuration registers
  logic [BANDS-1:0][SAMPLE_BITS-1:0]   threshold;
  logic [BANDS-1:0][CFG_DATA_BITS-1:0] times;

  // sequencer state
  logic [1:0]             phase_reg, phase_next;
  logic [TIME_BITS-1:0]   elapsed_ms, elapsed_next;
  logic [SAMPLE_BITS-1:0] peak_reg, peak_next;

  // input stage
  logic  s1_valid;
  item_t s1_item;

  // handshake
  logic out_ready;
  logic s1_fire;
  logic item_take;

  // datapath
  logic [BANDS-1:0]       ge;
  logic [BAND_BITS-1:0]   band_sel;
  logic                   below;
  logic [BAND_BITS-1:0]   band_out;
  logic [SAMPLE_BITS-1:0] peak_base;
  logic [TIME_BITS-1:0]   elapsed_inc;
  logic [TIME_BITS-1:0]   limit;
  logic                   running;

  assign cfg_ready = 1'b1;

  // ---- configuration ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold[0] <= THRESHOLD0_RST;
      threshold[1] <= THRESHOLD1_RST;
      threshold[2] <= THRESHOLD2_RST;
      threshold[3] <= THRESHOLD3_RST;
      times[0]     <= TIMES_RST;
      times[1]     <= TIMES_RST;
      times[2]     <= TIMES_RST;
      times[3]     <= TIMES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD0: threshold[0] <= cfg_data[SAMPLE_BITS-1:0];
        CFG_THRESHOLD1: threshold[1] <= cfg_data[SAMPLE_BITS-1:0];
        CFG_THRESHOLD2: threshold[2] <= cfg_data[SAMPLE_BITS-1:0];
        CFG_THRESHOLD3: threshold[3] <= cfg_data[SAMPLE_BITS-1:0];
        CFG_TIMES0:     times[0]     <= cfg_data;
        CFG_TIMES1:     times[1]     <= cfg_data;
        CFG_TIMES2:     times[2]     <= cfg_data;
        CFG_TIMES3:     times[3]     <= cfg_data;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // ---- handshake ----------------------------------------------------------
  // The result register frees up when empty or when its transfer completes.
  assign out_ready  = !result_valid || !result_stall;
  assign s1_fire    = s1_valid && out_ready;
  assign item_stall = s1_valid && !out_ready;
  assign item_take  = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_take) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_item <= item;
    end
  end

  // ---- band classification ------------------------------------------------
  // Thresholds are tested from band 3 down; the first one met wins, so an
  // unordered threshold set still resolves the same way.
  always_comb begin
    for (int i = 0; i < BANDS; i++) begin
      ge[i] = (s1_item.sample >= threshold[i]);
    end
    if (ge[3]) begin
      band_sel = 2'd3;
    end else if (ge[2]) begin
      band_sel = 2'd2;
    end else if (ge[1]) begin
      band_sel = 2'd1;
    end else begin
      band_sel = 2'd0;
    end
    below = !(|ge);
  end

  // ---- peak tracking ------------------------------------------------------
  // clear_peak applies before the sample, so a clear loads the sample itself
  always_comb begin
    peak_base = s1_item.clear_peak ? '0 : peak_reg;
    peak_next = (s1_item.sample > peak_base) ? s1_item.sample : peak_base;
  end

  // ---- phase sequencer ----------------------------------------------------
  always_comb begin
    running     = (phase_reg == PH_ON) || (phase_reg == PH_OFF);
    elapsed_inc = (elapsed_ms == TIME_MAX) ? elapsed_ms : elapsed_ms + 1'b1;
    // on-time sits in the upper half of the band's times word
    limit       = (phase_reg == PH_ON) ? times[band_sel][CFG_DATA_BITS-1:TIME_BITS]
                                       : times[band_sel][TIME_BITS-1:0];
    phase_next   = phase_reg;
    elapsed_next = elapsed_ms;
    band_out     = '0;
    if (!running) begin
      // idle (an unused code is handled as idle); a sample at or above threshold 0 starts a burst
      phase_next = PH_IDLE;
      if (ge[0]) begin
        phase_next   = PH_ON;
        elapsed_next = '0;
        band_out     = band_sel;
      end
    end else if (below) begin
      phase_next   = PH_IDLE;
      elapsed_next = '0;
    end else begin
      band_out = band_sel;
      if (elapsed_inc >= limit) begin
        // phase complete: flip and restart the count
        phase_next   = (phase_reg == PH_ON) ? PH_OFF : PH_ON;
        elapsed_next = '0;
      end else begin
        elapsed_next = elapsed_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg  <= PH_IDLE;
      elapsed_ms <= '0;
      peak_reg   <= '0;
    end else if (s1_fire) begin
      phase_reg  <= phase_next;
      elapsed_ms <= elapsed_next;
      peak_reg   <= peak_next;
    end
  end

  // ---- result register ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result.relay_on    <= (phase_next == PH_ON);
      result.phase       <= phase_next;
      result.band        <= band_out;
      result.peak_sample <= peak_next;
    end
  end

  // ---- assertions ---------------------------------------------------------
  `PBPD_ASSERT_NOW(a_relay_phase, clk, rst, result_valid && result.relay_on, result.phase == PH_ON)
  `PBPD_ASSERT_NOW(a_idle_band, clk, rst, result_valid && (result.phase == PH_IDLE), result.band == 2'd0)
  `PBPD_ASSERT_NOW(a_idle_count, clk, rst, phase_reg == PH_IDLE, elapsed_ms == '0)
  `PBPD_ASSERT_NEXT(a_fire_result, clk, rst, s1_fire, result_valid && (result.peak_sample == peak_reg))
  `PBPD_ASSERT_NEXT(a_peak_grows, clk, rst, s1_fire && !s1_item.clear_peak, peak_reg >= $past(peak_reg))

endmodule
